### hdl/qs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qs_pkg: shared constants for the key/payload quicksort block
// Default sizes and the key compare helper.
// ----------------------------------------------------------------------------
package qs_pkg;
    localparam int QS_DEPTH       = 64;
    localparam int QS_CUTOFF      = 7;
    localparam int QS_STACK_DEPTH = 16;
    localparam int KEY_W          = 32;
    localparam int PAY_W          = 32;

    // signed compare, a > b
    function automatic logic key_gt(input logic [KEY_W-1:0] a, input logic [KEY_W-1:0] b);
        key_gt = $signed(a) > $signed(b);
    endfunction
endpackage

### hdl/qs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qs_ram: generic single-port RAM
// Each cycle reads the addressed word and may also write it; read data is registered.
// ----------------------------------------------------------------------------
module qs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

### hdl/quicksort_key_payload_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quicksort_key_payload_top: batch key/payload sorter
// Collects words until i_last_in, sorts them by signed key (quicksort with
// median-of-three pivot, insertion sort below the cutoff, explicit bound
// stack), then emits the sorted words with o_last_out on the final one.
//
// Input channel: i_valid / o_stall. One word is stored per cycle while
// loading. A word beyond DEPTH is dropped and flags o_overflow on the batch.
// After the last word o_stall stays high through the sort and the output.
// The sort uses the key compare helper over one RAM port per store; a
// swap reads both entries (S_SWAP_RA, S_SWAP_RB) and writes them back
// (S_SWAP_WA, S_SWAP_WB); an insertion shift reads, compares and writes.
// Each sorted word is read through S_OUT_RD and S_OUT_WAIT into the output
// register, and the next word is read only after the held one is taken.
// Output channel: o_valid / i_stall; a stalled word holds.
// Reset clears the count, the overflow flag and the sequencer; the stores
// are not cleared.
// ----------------------------------------------------------------------------
module quicksort_key_payload_top
    import qs_pkg::*;
#(
    parameter int DEPTH            = QS_DEPTH,
    parameter int INSERTION_CUTOFF = QS_CUTOFF,
    parameter int STACK_DEPTH      = QS_STACK_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [KEY_W-1:0] i_key,
    input  logic [PAY_W-1:0] i_payload,
    input  logic             i_last_in,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [KEY_W-1:0] o_sorted_key,
    output logic [PAY_W-1:0] o_sorted_payload,
    output logic             o_last_out,
    output logic             o_overflow
);
    localparam int AW  = $clog2(DEPTH);
    localparam int IW  = $clog2(DEPTH + 3) + 1;  // signed working index
    localparam int SW  = $clog2(STACK_DEPTH + 1);
    localparam int SAW = $clog2(STACK_DEPTH);

    typedef logic signed [IW-1:0] t_idx;

    typedef enum logic [4:0] {
        S_LOAD, S_TOP, S_INS_J, S_INS_RDJ, S_INS_I, S_INS_CMP, S_INS_WR,
        S_INS_PUT, S_POP, S_SWAP_RA, S_SWAP_RB, S_SWAP_WA, S_SWAP_WB,
        S_MED_SEL, S_MED_RA, S_MED_RB, S_MED_CMP, S_PIV, S_SCAN_I, S_SCAN_IC,
        S_SCAN_J, S_SCAN_JC, S_FIN_RD, S_FIN_WR, S_FIN_PUT, S_PUSH, S_OUT_RD,
        S_OUT_WAIT, S_OUT
    } t_state;

    t_state r_state;
    t_state r_ret;
    logic [AW:0]      r_count;
    logic             r_ovf;
    t_idx             r_l, r_ir, r_i, r_j, r_sa, r_sb;
    logic [1:0]       r_med;
    logic [SW-1:0]    r_sp;
    logic [KEY_W-1:0] r_ak, r_tk;
    logic [PAY_W-1:0] r_ap, r_tp;
    logic [AW:0]      r_oidx;
    logic             r_ovalid;
    logic             r_olast;
    logic             r_oovf;
    logic [KEY_W-1:0] r_ok;
    logic [PAY_W-1:0] r_op;
    logic [IW-1:0]    r_stk [STACK_DEPTH];

    logic             ram_we;
    logic [AW-1:0]    ram_addr;
    logic [KEY_W-1:0] ram_wk, ram_rk;
    logic [PAY_W-1:0] ram_wp, ram_rp;
    logic             in_acc;
    logic             out_acc;

    assign in_acc  = i_valid && !o_stall;
    assign out_acc = r_ovalid && !i_stall;
    assign o_stall = (r_state != S_LOAD);

    qs_ram #(.WIDTH(KEY_W), .DEPTH(DEPTH)) u_key_ram (
        .i_clk(i_clk), .i_we(ram_we), .i_addr(ram_addr), .i_wdata(ram_wk),
        .o_rdata(ram_rk));
    qs_ram #(.WIDTH(PAY_W), .DEPTH(DEPTH)) u_pay_ram (
        .i_clk(i_clk), .i_we(ram_we), .i_addr(ram_addr), .i_wdata(ram_wp),
        .o_rdata(ram_rp));

    function automatic logic [AW-1:0] a_of(input t_idx x);
        t_idx y;
        y = x - t_idx'(1);
        a_of = y[AW-1:0];
    endfunction

    always_comb begin
        ram_we   = 1'b0;
        ram_addr = a_of(r_j);
        ram_wk   = i_key;
        ram_wp   = i_payload;
        case (r_state)
            S_LOAD: begin
                ram_addr = r_count[AW-1:0];
                ram_we   = in_acc && (r_count < (AW+1)'(DEPTH));
            end
            S_INS_RDJ, S_SCAN_JC, S_FIN_RD: ram_addr = a_of(r_j);
            S_INS_I, S_SCAN_IC: ram_addr = a_of(r_i);
            S_INS_WR: begin
                ram_addr = a_of(r_i + t_idx'(1));
                ram_we = 1'b1; ram_wk = r_tk; ram_wp = r_tp;
            end
            S_INS_PUT: begin
                ram_addr = a_of(r_i + t_idx'(1));
                ram_we = 1'b1; ram_wk = r_ak; ram_wp = r_ap;
            end
            S_SWAP_RA, S_MED_RA: ram_addr = a_of(r_sa);
            S_SWAP_RB, S_MED_RB, S_MED_CMP: ram_addr = a_of(r_sb);
            S_SWAP_WA: begin
                ram_addr = a_of(r_sa);
                ram_we = 1'b1; ram_wk = ram_rk; ram_wp = ram_rp;
            end
            S_SWAP_WB: begin
                ram_addr = a_of(r_sb);
                ram_we = 1'b1; ram_wk = r_tk; ram_wp = r_tp;
            end
            S_PIV: ram_addr = a_of(r_l + t_idx'(1));
            S_FIN_WR: begin
                ram_addr = a_of(r_l + t_idx'(1));
                ram_we = 1'b1; ram_wk = ram_rk; ram_wp = ram_rp;
            end
            S_FIN_PUT: begin
                ram_addr = a_of(r_j);
                ram_we = 1'b1; ram_wk = r_ak; ram_wp = r_ap;
            end
            S_OUT_RD: ram_addr = r_oidx[AW-1:0];
            default: ram_addr = a_of(r_j);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_ret    <= S_LOAD;
            r_count  <= '0;
            r_ovf    <= 1'b0;
            r_ovalid <= 1'b0;
            r_sp     <= '0;
            r_med    <= '0;
        end else begin
            case (r_state)
                S_LOAD: begin
                    if (in_acc) begin
                        if (r_count < (AW+1)'(DEPTH)) begin
                            r_count <= r_count + 1'b1;
                        end else begin
                            r_ovf <= 1'b1;
                        end
                        if (i_last_in) begin
                            r_l     <= t_idx'(1);
                            r_ir    <= (r_count < (AW+1)'(DEPTH)) ?
                                       t_idx'(r_count) + t_idx'(1) : t_idx'(r_count);
                            r_sp    <= '0;
                            r_state <= S_TOP;
                        end
                    end
                end
                S_TOP: begin
                    if ((r_ir - r_l) < t_idx'(INSERTION_CUTOFF) ||
                        (32'(r_sp) + 2) > STACK_DEPTH) begin
                        r_j     <= r_l + t_idx'(1);
                        r_state <= S_INS_J;
                    end else begin
                        r_sa    <= (r_l + r_ir) >>> 1;
                        r_sb    <= r_l + t_idx'(1);
                        r_ret   <= S_MED_SEL;
                        r_med   <= 2'd0;
                        r_state <= S_SWAP_RA;
                    end
                end
                S_INS_J: begin
                    r_state <= (r_j <= r_ir) ? S_INS_RDJ : S_POP;
                end
                S_INS_RDJ: begin
                    r_i     <= r_j - t_idx'(1);
                    r_state <= S_INS_I;
                end
                S_INS_I: begin
                    if (r_i == r_j - t_idx'(1)) begin
                        r_ak <= ram_rk; r_ap <= ram_rp;
                    end
                    r_state <= (r_i >= r_l) ? S_INS_CMP : S_INS_PUT;
                end
                S_INS_CMP: begin
                    if (key_gt(ram_rk, r_ak)) begin
                        r_tk <= ram_rk; r_tp <= ram_rp;
                        r_state <= S_INS_WR;
                    end else begin
                        r_state <= S_INS_PUT;
                    end
                end
                S_INS_WR: begin
                    r_i     <= r_i - t_idx'(1);
                    r_state <= S_INS_I;
                end
                S_INS_PUT: begin
                    r_j     <= r_j + t_idx'(1);
                    r_state <= S_INS_J;
                end
                S_POP: begin
                    if (r_sp < SW'(2)) begin
                        r_oidx  <= '0;
                        r_state <= (r_count == '0) ? S_LOAD : S_OUT_RD;
                    end else begin
                        r_ir    <= t_idx'(r_stk[SAW'(r_sp - SW'(1))]);
                        r_l     <= t_idx'(r_stk[SAW'(r_sp - SW'(2))]);
                        r_sp    <= r_sp - SW'(2);
                        r_state <= S_TOP;
                    end
                end
                S_SWAP_RA: r_state <= S_SWAP_RB;
                S_SWAP_RB: begin
                    r_tk <= ram_rk; r_tp <= ram_rp;
                    r_state <= S_SWAP_WA;
                end
                S_SWAP_WA: r_state <= S_SWAP_WB;
                S_SWAP_WB: r_state <= r_ret;
                S_MED_SEL: begin
                    case (r_med)
                        2'd0: begin r_sa <= r_l;             r_sb <= r_ir;            end
                        2'd1: begin r_sa <= r_l + t_idx'(1); r_sb <= r_ir;            end
                        default: begin r_sa <= r_l;          r_sb <= r_l + t_idx'(1); end
                    endcase
                    r_state <= (r_med == 2'd3) ? S_PIV : S_MED_RA;
                end
                S_MED_RA: r_state <= S_MED_RB;
                S_MED_RB: begin
                    r_tk <= ram_rk; r_tp <= ram_rp;
                    r_state <= S_MED_CMP;
                end
                S_MED_CMP: begin
                    r_med   <= r_med + 2'd1;
                    r_ret   <= S_MED_SEL;
                    r_state <= key_gt(r_tk, ram_rk) ? S_SWAP_WA : S_MED_SEL;
                end
                S_PIV: begin
                    r_i     <= r_l + t_idx'(1);
                    r_j     <= r_ir;
                    r_state <= S_SCAN_I;
                end
                S_SCAN_I: begin
                    if (r_i == r_l + t_idx'(1)) begin
                        r_ak <= ram_rk; r_ap <= ram_rp;
                    end
                    r_i     <= r_i + t_idx'(1);
                    r_state <= S_SCAN_IC;
                end
                S_SCAN_IC: r_state <= S_SCAN_J;
                S_SCAN_J: begin
                    if (r_i < r_ir && key_gt(r_ak, ram_rk)) begin
                        r_i     <= r_i + t_idx'(1);
                        r_state <= S_SCAN_IC;
                    end else begin
                        r_j     <= r_j - t_idx'(1);
                        r_state <= S_SCAN_JC;
                    end
                end
                S_SCAN_JC: r_state <= S_FIN_RD;
                S_FIN_RD: begin
                    if (r_j > r_l && key_gt(ram_rk, r_ak)) begin
                        r_j     <= r_j - t_idx'(1);
                        r_state <= S_SCAN_JC;
                    end else if (r_j < r_i) begin
                        r_state <= S_FIN_WR;
                    end else begin
                        r_sa    <= r_i;
                        r_sb    <= r_j;
                        r_ret   <= S_SCAN_I;
                        r_state <= S_SWAP_RA;
                    end
                end
                S_FIN_WR: r_state <= S_FIN_PUT;
                S_FIN_PUT: r_state <= S_PUSH;
                S_PUSH: begin
                    if (r_ir - r_i + t_idx'(1) >= r_j - r_l) begin
                        r_stk[SAW'(r_sp)]           <= r_i;
                        r_stk[SAW'(r_sp + SW'(1))]  <= r_ir;
                        r_ir <= r_j - t_idx'(1);
                    end else begin
                        r_stk[SAW'(r_sp)]           <= r_l;
                        r_stk[SAW'(r_sp + SW'(1))]  <= r_j - t_idx'(1);
                        r_l <= r_i;
                    end
                    r_sp    <= r_sp + SW'(2);
                    r_state <= S_TOP;
                end
                S_OUT_RD: r_state <= S_OUT_WAIT;
                S_OUT_WAIT: begin
                    r_ok     <= ram_rk;
                    r_op     <= ram_rp;
                    r_olast  <= (r_oidx + 1'b1) == r_count;
                    r_oovf   <= r_ovf;
                    r_ovalid <= 1'b1;
                    r_state  <= S_OUT;
                end
                S_OUT: begin
                    if (out_acc) begin
                        r_ovalid <= 1'b0;
                        if (r_olast) begin
                            r_count <= '0;
                            r_ovf   <= 1'b0;
                            r_state <= S_LOAD;
                        end else begin
                            r_oidx  <= r_oidx + 1'b1;
                            r_state <= S_OUT_RD;
                        end
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    assign o_valid          = r_ovalid;
    assign o_sorted_key     = r_ok;
    assign o_sorted_payload = r_op;
    assign o_last_out       = r_olast;
    assign o_overflow       = r_oovf;

    a_stall_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> o_stall) else $error("input open during output");
    a_sp_even: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_sp[0]) else $error("stack pointer odd");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (AW+1)'(DEPTH)) else $error("count past depth");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && i_stall |=> r_ovalid && $stable(r_ok))
        else $error("output changed under stall");
endmodule
